// ===== design/ccd_pkg.sv =====
// Shared types and constants for the clock and countdown timer.
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int TPS_W       = 16;
    localparam int PRESC_W     = TPS_W;
    localparam int CLK_HOUR_W  = 5;
    localparam int DOWN_HOUR_W = 7;
    localparam int MINSEC_W    = 6;
    localparam int LOAD_W      = 7;
    localparam int CMD_W       = 2;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    localparam logic [MINSEC_W-1:0]    MINSEC_MAX    = 6'd59;
    localparam logic [CLK_HOUR_W-1:0]  CLK_HOUR_MAX  = 5'd23;
    localparam logic [DOWN_HOUR_W-1:0] DOWN_HOUR_MAX = 7'd99;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Command codes on the request port
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_CLOCK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_DOWN  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_LOAD_CLOCK,
        OP_LOAD_DOWN,
        OP_NONE
    } t_op_kind;

    // Classified request as it travels from the front to the back
    typedef struct packed {
        t_op_kind                kind;
        logic [DOWN_HOUR_W-1:0]  hours;
        logic [MINSEC_W-1:0]     minutes;
        logic [MINSEC_W-1:0]     seconds;
        logic                    err;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/ccd_front.sv =====
// Request decode and load clamping for the clock and countdown timer.
`timescale 1ns / 1ps

module ccd_front
    import ccd_pkg::*;
(
    input  logic              i_valid,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [LOAD_W-1:0] i_load_hours,
    input  logic [LOAD_W-1:0] i_load_minutes,
    input  logic [LOAD_W-1:0] i_load_seconds,
    input  t_q_status         i_q_status,
    output logic              o_stall,
    output logic              o_push,
    output t_op               o_op
);

    logic                   hour_over;
    logic                   min_over;
    logic                   sec_over;
    logic [DOWN_HOUR_W-1:0] hour_lim;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        hour_lim = DOWN_HOUR_MAX;
        o_op.kind = OP_NONE;
        unique case (i_command)
            CMD_TICK: begin
                o_op.kind = OP_TICK;
            end
            CMD_LOAD_CLOCK: begin
                o_op.kind = OP_LOAD_CLOCK;
                hour_lim  = {{(DOWN_HOUR_W-CLK_HOUR_W){1'b0}}, CLK_HOUR_MAX};
            end
            CMD_LOAD_DOWN: begin
                o_op.kind = OP_LOAD_DOWN;
            end
            default: begin
                o_op.kind = OP_NONE;
            end
        endcase

        hour_over = i_load_hours > hour_lim;
        min_over  = i_load_minutes > {1'b0, MINSEC_MAX};
        sec_over  = i_load_seconds > {1'b0, MINSEC_MAX};

        // Clamp out-of-range values; flag only on load commands
        o_op.hours   = hour_over ? hour_lim : i_load_hours;
        o_op.minutes = min_over ? MINSEC_MAX : i_load_minutes[MINSEC_W-1:0];
        o_op.seconds = sec_over ? MINSEC_MAX : i_load_seconds[MINSEC_W-1:0];
        o_op.err     = (o_op.kind == OP_LOAD_CLOCK || o_op.kind == OP_LOAD_DOWN)
                       && (hour_over || min_over || sec_over);
    end

endmodule

// ===== design/ccd_queue.sv =====
// Short request queue between front and back of the clock and countdown timer.
`timescale 1ns / 1ps

module ccd_queue
    import ccd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_op,
    input  logic      i_pop,
    output t_op       o_op,
    output t_q_status o_status
);

    t_op                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_op           = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Clear both entries so the head never shows an unknown request kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

endmodule

// ===== design/ccd_back.sv =====
// Time-keeping state and result register of the clock and countdown timer.
`timescale 1ns / 1ps

module ccd_back
    import ccd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr,
    input  logic [TPS_W-1:0]       i_cfg_data,
    input  t_q_status              i_q_status,
    input  t_op                    i_op,
    output logic                   o_pop,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [CLK_HOUR_W-1:0]  o_clock_hours,
    output logic [MINSEC_W-1:0]    o_clock_minutes,
    output logic [MINSEC_W-1:0]    o_clock_seconds,
    output logic [DOWN_HOUR_W-1:0] o_countdown_hours,
    output logic [MINSEC_W-1:0]    o_countdown_minutes,
    output logic [MINSEC_W-1:0]    o_countdown_seconds,
    output logic                   o_second_elapsed,
    output logic                   o_range_error,
    output logic                   o_countdown_zero
);

    logic [TPS_W-1:0]       r_tps;
    logic [PRESC_W-1:0]     r_presc,  n_presc;
    logic [CLK_HOUR_W-1:0]  r_c_hour, n_c_hour;
    logic [MINSEC_W-1:0]    r_c_min,  n_c_min;
    logic [MINSEC_W-1:0]    r_c_sec,  n_c_sec;
    logic [DOWN_HOUR_W-1:0] r_d_hour, n_d_hour;
    logic [MINSEC_W-1:0]    r_d_min,  n_d_min;
    logic [MINSEC_W-1:0]    r_d_sec,  n_d_sec;
    logic                   r_out_valid;
    logic [PRESC_W:0]       presc_inc;
    logic                   elapsed;
    logic                   d_zero;

    assign o_pop   = !i_q_status.empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;

    always_comb begin
        n_presc  = r_presc;
        n_c_hour = r_c_hour;
        n_c_min  = r_c_min;
        n_c_sec  = r_c_sec;
        n_d_hour = r_d_hour;
        n_d_min  = r_d_min;
        n_d_sec  = r_d_sec;
        elapsed  = 1'b0;
        d_zero   = (r_d_hour == '0) && (r_d_min == '0) && (r_d_sec == '0);

        presc_inc = {1'b0, r_presc} + 1'b1;

        unique case (i_op.kind)
            OP_TICK: begin
                if (presc_inc >= {1'b0, r_tps}) begin
                    n_presc = '0;
                    elapsed = 1'b1;
                    // Clock counts up with wrap
                    if (r_c_sec >= MINSEC_MAX) begin
                        n_c_sec = '0;
                        if (r_c_min >= MINSEC_MAX) begin
                            n_c_min  = '0;
                            n_c_hour = (r_c_hour >= CLK_HOUR_MAX) ? '0 : r_c_hour + 1'b1;
                        end else begin
                            n_c_min = r_c_min + 1'b1;
                        end
                    end else begin
                        n_c_sec = r_c_sec + 1'b1;
                    end
                    // Countdown borrows, holds at zero
                    if (!d_zero) begin
                        if (r_d_sec != '0) begin
                            n_d_sec = r_d_sec - 1'b1;
                        end else begin
                            n_d_sec = MINSEC_MAX;
                            if (r_d_min != '0) begin
                                n_d_min = r_d_min - 1'b1;
                            end else begin
                                n_d_min  = MINSEC_MAX;
                                n_d_hour = r_d_hour - 1'b1;
                            end
                        end
                    end
                end else begin
                    n_presc = presc_inc[PRESC_W-1:0];
                end
            end
            OP_LOAD_CLOCK: begin
                n_c_hour = i_op.hours[CLK_HOUR_W-1:0];
                n_c_min  = i_op.minutes;
                n_c_sec  = i_op.seconds;
            end
            OP_LOAD_DOWN: begin
                n_d_hour = i_op.hours;
                n_d_min  = i_op.minutes;
                n_d_sec  = i_op.seconds;
            end
            OP_NONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_presc     <= '0;
            r_c_hour    <= '0;
            r_c_min     <= '0;
            r_c_sec     <= '0;
            r_d_hour    <= '0;
            r_d_min     <= '0;
            r_d_sec     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_tps <= i_cfg_data;
            end
            if (o_pop) begin
                r_presc     <= n_presc;
                r_c_hour    <= n_c_hour;
                r_c_min     <= n_c_min;
                r_c_sec     <= n_c_sec;
                r_d_hour    <= n_d_hour;
                r_d_min     <= n_d_min;
                r_d_sec     <= n_d_sec;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_clock_hours       <= n_c_hour;
            o_clock_minutes     <= n_c_min;
            o_clock_seconds     <= n_c_sec;
            o_countdown_hours   <= n_d_hour;
            o_countdown_minutes <= n_d_min;
            o_countdown_seconds <= n_d_sec;
            o_second_elapsed    <= elapsed;
            o_range_error       <= i_op.err;
            o_countdown_zero    <= (n_d_hour == '0) && (n_d_min == '0) && (n_d_sec == '0);
        end
    end

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_countdown_zero == ((o_countdown_hours == '0) &&
                     (o_countdown_minutes == '0) && (o_countdown_seconds == '0))))
        else $error("countdown zero flag disagrees with countdown value");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_second_elapsed && o_range_error))
        else $error("second elapsed and range error together");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_clock_seconds) &&
                                  $stable(o_countdown_seconds)))
        else $error("stalled result changed");

endmodule

// ===== design/clock_and_countdown_timer.sv =====
// Top level of the clock and countdown timer: front, request queue and back.
`timescale 1ns / 1ps

// Real-time clock with countdown timer. Each request carries a command
// (millisecond tick, load clock, load countdown; the fourth code does nothing)
// and gives exactly one result showing both HH:MM:SS values after the update,
// plus second-elapsed, range-error and countdown-zero flags. Requests are taken
// one per cycle while o_stall is low: a request accepted at a clock edge is
// decoded and clamped in the front, parked in a two-entry queue, applied by the
// back when it pops the queue head and shown from the result register. The
// combinational update loop of the back (prescaler increment and compare, then
// the second/minute/hour carry and borrow chains) sets this rate.
// When the result side stalls, the queue absorbs up to two more requests before
// the request side sees stall. The ticks_per_second register (reset 1000, zero
// behaves as one) is written through its own port, which is always ready; write
// it only while no request is in flight. Loads leave the prescaler alone.

module clock_and_countdown_timer
    import ccd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [LOAD_W-1:0]      i_load_hours,
    input  logic [LOAD_W-1:0]      i_load_minutes,
    input  logic [LOAD_W-1:0]      i_load_seconds,

    // Result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CLK_HOUR_W-1:0]  o_clock_hours,
    output logic [MINSEC_W-1:0]    o_clock_minutes,
    output logic [MINSEC_W-1:0]    o_clock_seconds,
    output logic [DOWN_HOUR_W-1:0] o_countdown_hours,
    output logic [MINSEC_W-1:0]    o_countdown_minutes,
    output logic [MINSEC_W-1:0]    o_countdown_seconds,
    output logic                   o_second_elapsed,
    output logic                   o_range_error,
    output logic                   o_countdown_zero,

    // Tick rate register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [TPS_W-1:0]       i_cfg_data
);

    logic      push;
    logic      pop;
    t_op       front_op;
    t_op       head_op;
    t_q_status q_status;

    // Register is a plain flop, so take every write at once
    assign o_cfg_ready = 1'b1;

    // Decode and clamp the incoming request
    ccd_front u_front (
        .i_valid        (i_valid),
        .i_command      (i_command),
        .i_load_hours   (i_load_hours),
        .i_load_minutes (i_load_minutes),
        .i_load_seconds (i_load_seconds),
        .i_q_status     (q_status),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_op           (front_op)
    );

    // Hold classified requests until the back can apply them
    ccd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (front_op),
        .i_pop    (pop),
        .o_op     (head_op),
        .o_status (q_status)
    );

    // Advance the clock and countdown, register the result
    ccd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr            (i_cfg_valid && o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_q_status          (q_status),
        .i_op                (head_op),
        .o_pop               (pop),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_clock_hours       (o_clock_hours),
        .o_clock_minutes     (o_clock_minutes),
        .o_clock_seconds     (o_clock_seconds),
        .o_countdown_hours   (o_countdown_hours),
        .o_countdown_minutes (o_countdown_minutes),
        .o_countdown_seconds (o_countdown_seconds),
        .o_second_elapsed    (o_second_elapsed),
        .o_range_error       (o_range_error),
        .o_countdown_zero    (o_countdown_zero)
    );

endmodule
